// File: rtl/command_frame_checker_unit_defines.svh
// Assertion macros shared by the command frame checker's checker module.
`ifndef COMMAND_FRAME_CHECKER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("command frame checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("command frame checker: next-cycle property failed");

`endif

// File: rtl/cfc_pkg.sv
// Types, codes and helpers shared by the command frame checker.
package cfc_pkg;

	localparam int SLOTS  = 4;
	localparam int SLOT_W = 64;
	localparam int ARG_W  = 5;

	localparam logic [7:0] CH_START = 8'h21; // '!'
	localparam logic [7:0] CH_STAR  = 8'h2A; // '*'
	localparam logic [7:0] CH_COMMA = 8'h2C; // ','

	localparam logic [2:0] CFG_NAME_SLOT_0 = 3'd0;
	localparam logic [2:0] CFG_NAME_SLOT_1 = 3'd1;
	localparam logic [2:0] CFG_NAME_SLOT_2 = 3'd2;
	localparam logic [2:0] CFG_NAME_SLOT_3 = 3'd3;
	localparam logic [2:0] CFG_ENTRY_COUNT = 3'd4;

	typedef enum logic [4:0] {
		PH_SEEK = 5'b00001,
		PH_BODY = 5'b00010,
		PH_HEX1 = 5'b00100,
		PH_HEX2 = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_IGNORED  = 2'd0,
		ST_OK       = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] index;
	} match_t;

	typedef struct packed {
		logic [ARG_W-1:0] arg_length;
		logic             has_args;
		logic [1:0]       command_index;
		status_t          status;
	} result_t;

	// Bit 4 set: not a hex digit; otherwise bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'h10;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			r = {1'b0, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46)
			r = {1'b0, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

// File: rtl/cfc_name_match.sv
// Compares the collected command name with the registered name slots.
module cfc_name_match #(
	parameter int MAX_COMMANDS = 4,
	parameter int NAME_CHARS   = 8
) (
	input  logic [cfc_pkg::SLOTS-1:0][cfc_pkg::SLOT_W-1:0] name_slot,
	input  logic [2:0]                                     entry_count,
	input  logic [8*NAME_CHARS-1:0]                        name_buffer,
	input  logic [$clog2(NAME_CHARS+2)-1:0]                name_length,
	output cfc_pkg::match_t                                match
);

	localparam int NLW   = $clog2(NAME_CHARS + 2);
	localparam int CAP_I = (MAX_COMMANDS < cfc_pkg::SLOTS) ? MAX_COMMANDS : cfc_pkg::SLOTS;
	localparam logic [2:0] CAP = 3'(CAP_I);

	always_comb begin
		logic [2:0]     count;
		logic [NLW-1:0] slen;
		logic           stop;
		logic           equal;
		match = '0;
		count = (entry_count > CAP) ? CAP : entry_count;
		for (int i = 0; i < cfc_pkg::SLOTS; i++) begin
			slen = '0;
			stop = 1'b0;
			// name length: bytes before the first zero byte
			for (int k = 0; k < NAME_CHARS; k++) begin
				if (!stop && name_slot[i][8*k +: 8] != 8'h00)
					slen = slen + 1'b1;
				else
					stop = 1'b1;
			end
			equal = 1'b1;
			for (int k = 0; k < NAME_CHARS; k++) begin
				if (NLW'(k) < slen && name_slot[i][8*k +: 8] != name_buffer[8*k +: 8])
					equal = 1'b0;
			end
			if (!match.hit && 3'(i) < count && slen == name_length && equal) begin
				match.hit   = 1'b1;
				match.index = 2'(i);
			end
		end
	end

endmodule

// File: rtl/cfc_line_parser.sv
// Per-line state and byte-by-byte parse of one command line.
module cfc_line_parser #(
	parameter int MAX_COMMANDS = 4,
	parameter int NAME_CHARS   = 8,
	parameter int ARG_BUFFER   = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           step,
	input  logic [7:0]                                     byte_value,
	input  logic                                           last,
	input  logic [cfc_pkg::SLOTS-1:0][cfc_pkg::SLOT_W-1:0] name_slot,
	input  logic [2:0]                                     entry_count,
	output cfc_pkg::result_t                               result
);

	localparam int NLW       = $clog2(NAME_CHARS + 2);
	localparam int ARG_LIM_I = (ARG_BUFFER - 1 > 31) ? 31 : ARG_BUFFER - 1;
	localparam logic [cfc_pkg::ARG_W-1:0] ARG_LIMIT = cfc_pkg::ARG_W'(ARG_LIM_I);

	cfc_pkg::phase_t            phase_q, phase_d;
	logic [7:0]                 xor_q, xor_d;
	logic [3:0]                 high_q, high_d;
	logic                       body_q, body_d;
	logic                       comma_q, comma_d;
	logic [NLW-1:0]             name_cnt_q, name_cnt_d;
	logic [8*NAME_CHARS-1:0]    name_buf_q, name_buf_d;
	logic [cfc_pkg::ARG_W-1:0]  args_q, args_d;
	cfc_pkg::status_t           held_status_q, held_status_d;
	logic [1:0]                 held_index_q, held_index_d;
	cfc_pkg::match_t            match;
	logic [4:0]                 hex;
	logic                       split;

	cfc_name_match #(
		.MAX_COMMANDS (MAX_COMMANDS),
		.NAME_CHARS   (NAME_CHARS)
	) u_match (
		.name_slot   (name_slot),
		.entry_count (entry_count),
		.name_buffer (name_buf_q),
		.name_length (name_cnt_q),
		.match       (match)
	);

	assign hex = cfc_pkg::hex_decode(byte_value);

	always_comb begin
		phase_d       = phase_q;
		xor_d         = xor_q;
		high_d        = high_q;
		body_d        = body_q;
		comma_d       = comma_q;
		name_cnt_d    = name_cnt_q;
		name_buf_d    = name_buf_q;
		args_d        = args_q;
		held_status_d = held_status_q;
		held_index_d  = held_index_q;

		if (byte_value != 8'h00) begin
			unique case (phase_q)
				cfc_pkg::PH_SEEK: begin
					if (byte_value == cfc_pkg::CH_START)
						phase_d = cfc_pkg::PH_BODY;
				end
				cfc_pkg::PH_BODY: begin
					if (byte_value == cfc_pkg::CH_STAR) begin
						if (!body_q) begin
							held_status_d = cfc_pkg::ST_CHECKSUM;
							held_index_d  = '0;
							phase_d       = cfc_pkg::PH_DONE;
						end else begin
							phase_d = cfc_pkg::PH_HEX1;
						end
					end else begin
						body_d = 1'b1;
						xor_d  = xor_q ^ byte_value;
						if (comma_q) begin
							if (args_q < ARG_LIMIT)
								args_d = args_q + 1'b1;
						end else if (byte_value == cfc_pkg::CH_COMMA) begin
							comma_d = 1'b1;
						end else begin
							for (int k = 0; k < NAME_CHARS; k++) begin
								if (name_cnt_q == NLW'(k))
									name_buf_d[8*k +: 8] = byte_value;
							end
							// saturate one past the longest name so overlong names miss
							if (name_cnt_q <= NLW'(NAME_CHARS))
								name_cnt_d = name_cnt_q + 1'b1;
						end
					end
				end
				cfc_pkg::PH_HEX1: begin
					if (hex[4]) begin
						held_status_d = cfc_pkg::ST_CHECKSUM;
						held_index_d  = '0;
						phase_d       = cfc_pkg::PH_DONE;
					end else begin
						high_d  = hex[3:0];
						phase_d = cfc_pkg::PH_HEX2;
					end
				end
				cfc_pkg::PH_HEX2: begin
					phase_d = cfc_pkg::PH_DONE;
					if (hex[4] || {high_q, hex[3:0]} != xor_q) begin
						held_status_d = cfc_pkg::ST_CHECKSUM;
						held_index_d  = '0;
					end else if (match.hit) begin
						held_status_d = cfc_pkg::ST_OK;
						held_index_d  = match.index;
					end else begin
						held_status_d = cfc_pkg::ST_UNKNOWN;
						held_index_d  = '0;
					end
				end
				cfc_pkg::PH_DONE: begin
				end
				default: begin
				end
			endcase
		end

		// settle an open verdict when the content ends
		if (byte_value == 8'h00 || last) begin
			if (phase_d == cfc_pkg::PH_SEEK) begin
				held_status_d = cfc_pkg::ST_IGNORED;
				held_index_d  = '0;
				phase_d       = cfc_pkg::PH_DONE;
			end else if (phase_d != cfc_pkg::PH_DONE) begin
				held_status_d = cfc_pkg::ST_CHECKSUM;
				held_index_d  = '0;
				phase_d       = cfc_pkg::PH_DONE;
			end
		end
	end

	assign split = (held_status_d == cfc_pkg::ST_OK) || (held_status_d == cfc_pkg::ST_UNKNOWN);

	always_comb begin
		result.status        = held_status_d;
		result.command_index = (held_status_d == cfc_pkg::ST_OK) ? held_index_d : 2'd0;
		result.has_args      = split && comma_d;
		result.arg_length    = split ? args_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= cfc_pkg::PH_SEEK;
			xor_q         <= '0;
			high_q        <= '0;
			body_q        <= 1'b0;
			comma_q       <= 1'b0;
			name_cnt_q    <= '0;
			name_buf_q    <= '0;
			args_q        <= '0;
			held_status_q <= cfc_pkg::ST_IGNORED;
			held_index_q  <= '0;
		end else if (step) begin
			if (last) begin
				// line over: back to the start of a fresh line
				phase_q       <= cfc_pkg::PH_SEEK;
				xor_q         <= '0;
				high_q        <= '0;
				body_q        <= 1'b0;
				comma_q       <= 1'b0;
				name_cnt_q    <= '0;
				name_buf_q    <= '0;
				args_q        <= '0;
				held_status_q <= cfc_pkg::ST_IGNORED;
				held_index_q  <= '0;
			end else begin
				phase_q       <= phase_d;
				xor_q         <= xor_d;
				high_q        <= high_d;
				body_q        <= body_d;
				comma_q       <= comma_d;
				name_cnt_q    <= name_cnt_d;
				name_buf_q    <= name_buf_d;
				args_q        <= args_d;
				held_status_q <= held_status_d;
				held_index_q  <= held_index_d;
			end
		end
	end

endmodule

// File: rtl/command_frame_checker_unit.sv
// Command frame checker: one byte per beat in, one verdict beat per line out.
// Each accepted byte lands in an input register and is parsed from it,
// so the unit takes one byte every clock while the result side keeps up;
// the verdict beat is registered in the output register when the line's
// final byte (tlast) leaves the input register and waits there, stalling
// input only when a further final byte arrives before it is taken. Bytes
// before the first '!' are skipped, the body up to '*' is XOR checked against
// two hex digits, and the name before the first ',' is looked up in the name
// slots in order. A zero byte ends the line's content early. Write the slots
// and the entry count only while no line is in flight.
module command_frame_checker_unit #(
	parameter int MAX_COMMANDS = 4,
	parameter int NAME_CHARS   = 8,
	parameter int ARG_BUFFER   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] status, [3:2] command_index, [4] has_args,
	                               // [9:5] arg_length, [15:10] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic                                           valid_s1;
	logic [7:0]                                     byte_s1;
	logic                                           last_s1;
	logic                                           advance;
	logic                                           m_valid_q;
	cfc_pkg::result_t                               result_q;
	cfc_pkg::result_t                               result;
	logic [cfc_pkg::SLOTS-1:0][cfc_pkg::SLOT_W-1:0] name_slot_q;
	logic [2:0]                                     entry_count_q;

	// a final byte may only move on when the output register is free
	assign advance  = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	cfc_line_parser #(
		.MAX_COMMANDS (MAX_COMMANDS),
		.NAME_CHARS   (NAME_CHARS),
		.ARG_BUFFER   (ARG_BUFFER)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.byte_value  (byte_s1),
		.last        (last_s1),
		.name_slot   (name_slot_q),
		.entry_count (entry_count_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1)
			result_q <= result;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_slot_q   <= '0;
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfc_pkg::CFG_NAME_SLOT_0: name_slot_q[0] <= cfg_data;
				cfc_pkg::CFG_NAME_SLOT_1: name_slot_q[1] <= cfg_data;
				cfc_pkg::CFG_NAME_SLOT_2: name_slot_q[2] <= cfg_data;
				cfc_pkg::CFG_NAME_SLOT_3: name_slot_q[3] <= cfg_data;
				cfc_pkg::CFG_ENTRY_COUNT: entry_count_q  <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/cfc_checker.sv
// Port-level checks on the command frame checker, bound to its top level.
`include "command_frame_checker_unit_defines.svh"

module cfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// hold a stalled verdict beat
	`CFC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

	// drop argument fields and index when the line was skipped or failed its check
	`CFC_ASSERT_NOW(a_fail_clean, clk, arst_n,
		m_tvalid && (m_tdata[1:0] == cfc_pkg::ST_IGNORED ||
			m_tdata[1:0] == cfc_pkg::ST_CHECKSUM),
		m_tdata[9:2] == 8'h00)

	`CFC_ASSERT_NOW(a_unknown_index, clk, arst_n,
		m_tvalid && m_tdata[1:0] == cfc_pkg::ST_UNKNOWN, m_tdata[3:2] == 2'd0)

	// no argument count without a comma
	`CFC_ASSERT_NOW(a_args_need_comma, clk, arst_n,
		m_tvalid && !m_tdata[4], m_tdata[9:5] == 5'd0)

endmodule

bind command_frame_checker_unit cfc_checker u_cfc_checker (.*);
